/* sv/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types, constants and helpers for the pick and place sequencer
// Holds the word formats of both channels, the register map, the arm pose
// targets and the fixed-point rounding helpers used for reset values and pose targets.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int NJOINTS             = 5;
    localparam int POS_FRAC_BITS_DEF   = 12;
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int DWELL_WIDTH_DEF     = 8;
    localparam int PADDR_W             = 5;
    localparam int PDATA_W             = 32;

    // Register indexes (byte address = 4 * index).
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_PICK_X     = 3'd0;
    localparam reg_idx_t REG_PICK_Z     = 3'd1;
    localparam reg_idx_t REG_PLACE_X    = 3'd2;
    localparam reg_idx_t REG_PLACE_Z    = 3'd3;
    localparam reg_idx_t REG_REACH_TOL  = 3'd4;
    localparam reg_idx_t REG_JOINT_TOL  = 3'd5;
    localparam reg_idx_t REG_GRIP_DWELL = 3'd6;
    localparam reg_idx_t REG_REL_DWELL  = 3'd7;

    // Arm pose codes.
    typedef logic [1:0] pose_t;
    localparam pose_t POSE_HOME  = 2'd0;
    localparam pose_t POSE_PREP  = 2'd1;
    localparam pose_t POSE_GRASP = 2'd2;

    // Joint speeds in tenths of rad/s.
    localparam logic [4:0] SPEED_FAST = 5'd18;
    localparam logic [4:0] SPEED_SLOW = 5'd12;
    localparam logic [4:0] SPEED_HOME = 5'd15;

    // Pose targets in milliradians, indexed by pose code and joint.
    localparam int POSE_MILLI [0:2][0:NJOINTS-1] = '{
        '{0, 1000, -1800, 1200, 0},
        '{0,  900, -1400,  900, 0},
        '{0, 1150, -1350,  600, 0}
    };

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
        logic               pos_valid;
        logic signed [15:0] joint0_angle;
        logic signed [15:0] joint1_angle;
        logic signed [15:0] joint2_angle;
        logic signed [15:0] joint3_angle;
        logic signed [15:0] joint4_angle;
    } pps_in_t;

    typedef struct packed {
        logic       drive_enable;
        logic       gripper_open;
        logic       arm_cmd_valid;
        logic [1:0] arm_pose;
        logic [4:0] arm_speed;
        logic [3:0] phase_out;
    } pps_out_t;

    typedef struct packed {
        logic signed [15:0] pick_target_x;
        logic signed [15:0] pick_target_z;
        logic signed [15:0] place_target_x;
        logic signed [15:0] place_target_z;
        logic [31:0]        reach_tol_sq;
        logic [14:0]        joint_tol;
        logic [7:0]         grip_dwell_ticks;
        logic [7:0]         release_dwell_ticks;
    } pps_cfg_t;

    // Arrival and pose checks for one tick, as found by the lanes.
    typedef struct packed {
        logic arrive_pick;
        logic arrive_place;
        logic at_prep;
        logic at_grasp;
    } pps_flags_t;

    // num/100 scaled by 2^frac, rounded half away from zero.
    function automatic longint fix_centi(input longint num, input int frac);
        longint mag;
        longint r;
        mag = (num < 0) ? -num : num;
        r   = (mag * (longint'(1) << frac) + 50) / 100;
        return (num < 0) ? -r : r;
    endfunction

    // num/1000 scaled by 2^frac, rounded half away from zero.
    function automatic longint fix_milli(input longint num, input int frac);
        longint mag;
        longint r;
        mag = (num < 0) ? -num : num;
        r   = (mag * (longint'(1) << frac) + 500) / 1000;
        return (num < 0) ? -r : r;
    endfunction

    function automatic logic [15:0] sat16(input longint v);
        longint s;
        s = v;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[15:0];
    endfunction

    function automatic logic [15:0] pose_target(input int pose_idx, input int joint,
                                                input int frac);
        longint t;
        t = fix_milli(longint'(POSE_MILLI[pose_idx][joint]), frac);
        return t[15:0];
    endfunction

endpackage

/* sv/pps_regs.sv */
// ----------------------------------------------------------------------------
// pps_regs: configuration register file
// Eight registers on a simple APB-style port; writes complete in the access
// cycle, reads return the stored value zero-extended.
// ----------------------------------------------------------------------------
module pps_regs
    import pps_pkg::*;
#(
    parameter int POS_FRAC_BITS   = POS_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output pps_cfg_t           cfg_reg
);

    localparam longint     TOL_FIX  = fix_centi(6, POS_FRAC_BITS);
    localparam longint     TOL_SAT  = (TOL_FIX > 32767) ? 32767 : TOL_FIX;
    localparam longint     TOL_SQ   = TOL_SAT * TOL_SAT;
    localparam longint     JTOL_FIX = fix_centi(3, ANGLE_FRAC_BITS);
    localparam logic [15:0] PICK_RST  = sat16(fix_centi(15, POS_FRAC_BITS));
    localparam logic [15:0] PLACE_RST = sat16(fix_centi(110, POS_FRAC_BITS));
    localparam logic [31:0] TOL_RST   = TOL_SQ[31:0];
    localparam logic [14:0] JTOL_RST  = JTOL_FIX[14:0];

    reg_idx_t idx;
    logic     wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pick_target_x       <= PICK_RST;
            cfg_reg.pick_target_z       <= PICK_RST;
            cfg_reg.place_target_x      <= '0;
            cfg_reg.place_target_z      <= PLACE_RST;
            cfg_reg.reach_tol_sq        <= TOL_RST;
            cfg_reg.joint_tol           <= JTOL_RST;
            cfg_reg.grip_dwell_ticks    <= 8'd21;
            cfg_reg.release_dwell_ticks <= 8'd18;
        end else if (wr_en) begin
            unique case (idx)
                REG_PICK_X:     cfg_reg.pick_target_x       <= pwdata[15:0];
                REG_PICK_Z:     cfg_reg.pick_target_z       <= pwdata[15:0];
                REG_PLACE_X:    cfg_reg.place_target_x      <= pwdata[15:0];
                REG_PLACE_Z:    cfg_reg.place_target_z      <= pwdata[15:0];
                REG_REACH_TOL:  cfg_reg.reach_tol_sq        <= pwdata[31:0];
                REG_JOINT_TOL:  cfg_reg.joint_tol           <= pwdata[14:0];
                REG_GRIP_DWELL: cfg_reg.grip_dwell_ticks    <= pwdata[7:0];
                REG_REL_DWELL:  cfg_reg.release_dwell_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_PICK_X:     prdata = {16'd0, cfg_reg.pick_target_x};
            REG_PICK_Z:     prdata = {16'd0, cfg_reg.pick_target_z};
            REG_PLACE_X:    prdata = {16'd0, cfg_reg.place_target_x};
            REG_PLACE_Z:    prdata = {16'd0, cfg_reg.place_target_z};
            REG_REACH_TOL:  prdata = cfg_reg.reach_tol_sq;
            REG_JOINT_TOL:  prdata = {17'd0, cfg_reg.joint_tol};
            REG_GRIP_DWELL: prdata = {24'd0, cfg_reg.grip_dwell_ticks};
            REG_REL_DWELL:  prdata = {24'd0, cfg_reg.release_dwell_ticks};
            default:        prdata = '0;
        endcase
    end

endmodule

/* sv/pps_dist_lane.sv */
// ----------------------------------------------------------------------------
// pps_dist_lane: squared distance lane
// Squares the x and z offsets between the base position and one target point.
// ----------------------------------------------------------------------------
module pps_dist_lane
    import pps_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_z,
    input  logic signed [15:0] tgt_x,
    input  logic signed [15:0] tgt_z,
    output logic [31:0]        sq_x_reg,
    output logic [31:0]        sq_z_reg
);

    logic signed [16:0] dx;
    logic signed [16:0] dz;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dz_sq;

    assign dx    = {tgt_x[15], tgt_x} - {pos_x[15], pos_x};
    assign dz    = {tgt_z[15], tgt_z} - {pos_z[15], pos_z};
    assign dx_sq = dx * dx;
    assign dz_sq = dz * dz;

    // A square of a 17-bit offset is below 2^32, so the low word is exact.
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg <= dx_sq[31:0];
            sq_z_reg <= dz_sq[31:0];
        end
    end

endmodule

/* sv/pps_joint_lane.sv */
// ----------------------------------------------------------------------------
// pps_joint_lane: per-joint pose check
// Tests one joint against its prepare and grasp targets within the tolerance.
// ----------------------------------------------------------------------------
module pps_joint_lane
    import pps_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int JOINT           = 0
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    input  logic [14:0]        joint_tol,
    output logic               at_prep_reg,
    output logic               at_grasp_reg
);

    localparam logic [15:0] PREP_T  = pose_target(int'(POSE_PREP), JOINT, ANGLE_FRAC_BITS);
    localparam logic [15:0] GRASP_T = pose_target(int'(POSE_GRASP), JOINT, ANGLE_FRAC_BITS);

    logic signed [16:0] d_prep;
    logic signed [16:0] d_grasp;
    logic [16:0]        a_prep;
    logic [16:0]        a_grasp;

    assign d_prep  = {angle[15], angle} - {PREP_T[15], PREP_T};
    assign d_grasp = {angle[15], angle} - {GRASP_T[15], GRASP_T};
    assign a_prep  = d_prep[16]  ? 17'(-d_prep)  : d_prep;
    assign a_grasp = d_grasp[16] ? 17'(-d_grasp) : d_grasp;

    always_ff @(posedge aclk) begin
        if (en) begin
            at_prep_reg  <= (a_prep  <= {2'b00, joint_tol});
            at_grasp_reg <= (a_grasp <= {2'b00, joint_tol});
        end
    end

endmodule

/* sv/pps_merge.sv */
// ----------------------------------------------------------------------------
// pps_merge: lane merge stage
// Adds the squared offsets, compares against the tolerance and combines the
// joint lanes into whole-pose flags.
// ----------------------------------------------------------------------------
module pps_merge
    import pps_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic               pos_valid,
    input  logic [31:0]        pick_sq_x,
    input  logic [31:0]        pick_sq_z,
    input  logic [31:0]        place_sq_x,
    input  logic [31:0]        place_sq_z,
    input  logic [NJOINTS-1:0] prep_ok,
    input  logic [NJOINTS-1:0] grasp_ok,
    input  logic [31:0]        reach_tol_sq,
    output pps_flags_t         flags_reg
);

    logic [32:0] pick_sum;
    logic [32:0] place_sum;

    assign pick_sum  = {1'b0, pick_sq_x}  + {1'b0, pick_sq_z};
    assign place_sum = {1'b0, place_sq_x} + {1'b0, place_sq_z};

    // Without a position fix the base is taken to have arrived.
    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg.arrive_pick  <= !pos_valid || (pick_sum  < {1'b0, reach_tol_sq});
            flags_reg.arrive_place <= !pos_valid || (place_sum < {1'b0, reach_tol_sq});
            flags_reg.at_prep      <= &prep_ok;
            flags_reg.at_grasp     <= &grasp_ok;
        end
    end

endmodule

/* sv/pps_seq.sv */
// ----------------------------------------------------------------------------
// pps_seq: phase sequencer
// Steps the nine-phase pick and place sequence once per word and builds the
// result word in the output register.
// ----------------------------------------------------------------------------
module pps_seq
    import pps_pkg::*;
#(
    parameter int DWELL_WIDTH = DWELL_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  pps_flags_t flags,
    input  logic [7:0] grip_dwell_ticks,
    input  logic [7:0] release_dwell_ticks,
    output pps_out_t   result_reg
);

    localparam int CMP_W = (DWELL_WIDTH > 8) ? DWELL_WIDTH : 8;
    localparam logic [DWELL_WIDTH-1:0] DWELL_MAX = {DWELL_WIDTH{1'b1}};

    typedef enum logic [3:0] {
        PH_DRIVE_PICK  = 4'd0,
        PH_PREPARE     = 4'd1,
        PH_GRASP       = 4'd2,
        PH_CLOSE       = 4'd3,
        PH_LIFT        = 4'd4,
        PH_DRIVE_PLACE = 4'd5,
        PH_LOWER       = 4'd6,
        PH_OPEN        = 4'd7,
        PH_DONE        = 4'd8
    } phase_t;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [DWELL_WIDTH-1:0] dwell_reg;
    logic [DWELL_WIDTH-1:0] dwell_next;
    logic [DWELL_WIDTH-1:0] dwell_inc;
    logic [CMP_W-1:0]       dwell_cmp;
    pps_out_t               result_next;

    assign dwell_inc = (dwell_reg == DWELL_MAX) ? dwell_reg : dwell_reg + 1'b1;
    assign dwell_cmp = CMP_W'(dwell_inc);

    always_comb begin
        phase_next  = phase_reg;
        dwell_next  = dwell_reg;
        result_next = '0;
        unique case (phase_reg)
            PH_DRIVE_PICK: begin
                if (flags.arrive_pick) begin
                    phase_next              = PH_PREPARE;
                    result_next.arm_cmd_valid = 1'b1;
                    result_next.arm_pose    = POSE_PREP;
                    result_next.arm_speed   = SPEED_FAST;
                end else begin
                    result_next.drive_enable = 1'b1;
                end
            end
            PH_PREPARE: begin
                if (flags.at_prep) begin
                    phase_next              = PH_GRASP;
                    result_next.arm_cmd_valid = 1'b1;
                    result_next.arm_pose    = POSE_GRASP;
                    result_next.arm_speed   = SPEED_SLOW;
                end
            end
            PH_GRASP: begin
                if (flags.at_grasp) begin
                    phase_next = PH_CLOSE;
                    dwell_next = '0;
                end
            end
            PH_CLOSE: begin
                dwell_next = dwell_inc;
                if (dwell_cmp > CMP_W'(grip_dwell_ticks)) begin
                    phase_next              = PH_LIFT;
                    result_next.arm_cmd_valid = 1'b1;
                    result_next.arm_pose    = POSE_PREP;
                    result_next.arm_speed   = SPEED_SLOW;
                end
            end
            PH_LIFT: begin
                if (flags.at_prep) begin
                    phase_next = PH_DRIVE_PLACE;
                end
            end
            PH_DRIVE_PLACE: begin
                if (flags.arrive_place) begin
                    phase_next              = PH_LOWER;
                    result_next.arm_cmd_valid = 1'b1;
                    result_next.arm_pose    = POSE_GRASP;
                    result_next.arm_speed   = SPEED_SLOW;
                end else begin
                    result_next.drive_enable = 1'b1;
                end
            end
            PH_LOWER: begin
                if (flags.at_grasp) begin
                    phase_next = PH_OPEN;
                    dwell_next = '0;
                end
            end
            PH_OPEN: begin
                dwell_next = dwell_inc;
                if (dwell_cmp > CMP_W'(release_dwell_ticks)) begin
                    phase_next              = PH_DONE;
                    result_next.arm_cmd_valid = 1'b1;
                    result_next.arm_pose    = POSE_HOME;
                    result_next.arm_speed   = SPEED_HOME;
                end
            end
            default: ;
        endcase
        result_next.gripper_open = !((phase_next == PH_CLOSE) || (phase_next == PH_LIFT) ||
                                     (phase_next == PH_DRIVE_PLACE) ||
                                     (phase_next == PH_LOWER));
        result_next.phase_out = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DRIVE_PICK;
            dwell_reg <= '0;
        end else if (load) begin
            phase_reg  <= phase_next;
            dwell_reg  <= dwell_next;
            result_reg <= result_next;
        end
    end

endmodule

/* sv/pick_place_sequencer.sv */
// ----------------------------------------------------------------------------
// pick_place_sequencer: pick and place sequencer, top level
// Three-stage pipeline: distance and joint lanes, merge, phase sequencer.
// ----------------------------------------------------------------------------
// Each input word is one control tick and yields exactly one result word.
// The block takes one word per clock cycle while s_ready is high. Three
// register stages stand between the channels (lane stage, merge stage,
// sequencer output register), and a word passes through them in that
// order. All arrival and pose tests are worked out for every candidate
// target before the phase is known, so the only loop back to earlier work
// is the phase and dwell registers inside the sequencer, which feed back on
// themselves and so set the one-word-per-cycle rate.
// Each pipeline stage holds its word until the next stage frees up. While a
// finished result waits at the output, the input is still taken until the two
// stages in front of it are full; from then on s_ready follows m_ready.
// The user must write configuration through the APB port while the pipeline is
// empty; the block does not enforce it. There is no start-up clearing pass.
// ----------------------------------------------------------------------------
module pick_place_sequencer
    import pps_pkg::*;
#(
    parameter int POS_FRAC_BITS   = POS_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int DWELL_WIDTH     = DWELL_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pps_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pps_out_t           m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    pps_cfg_t   cfg;
    pps_flags_t flags;

    // Stage occupancy. A stage moves on when the next one is empty or moving.
    logic valid1_reg;
    logic valid2_reg;
    logic valid3_reg;
    logic en1;
    logic en2;
    logic en3;

    logic               pos_valid1_reg;
    logic [31:0]        pick_sq_x;
    logic [31:0]        pick_sq_z;
    logic [31:0]        place_sq_x;
    logic [31:0]        place_sq_z;
    logic [NJOINTS-1:0] prep_ok;
    logic [NJOINTS-1:0] grasp_ok;
    logic signed [15:0] angle [NJOINTS];

    assign en3     = !valid3_reg || m_ready;
    assign en2     = !valid2_reg || en3;
    assign en1     = !valid1_reg || en2;
    assign s_ready = en1;
    assign m_valid = valid3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else begin
            if (en1) valid1_reg <= s_valid;
            if (en2) valid2_reg <= valid1_reg;
            if (en3) valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            pos_valid1_reg <= s_data.pos_valid;
        end
    end

    pps_regs #(
        .POS_FRAC_BITS  (POS_FRAC_BITS),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg_reg(cfg)
    );

    // Distance lanes: one for the pick point, one for the place point.
    pps_dist_lane u_pick_lane (
        .aclk    (aclk),
        .en      (en1),
        .pos_x   (s_data.pos_x),
        .pos_z   (s_data.pos_z),
        .tgt_x   (cfg.pick_target_x),
        .tgt_z   (cfg.pick_target_z),
        .sq_x_reg(pick_sq_x),
        .sq_z_reg(pick_sq_z)
    );

    pps_dist_lane u_place_lane (
        .aclk    (aclk),
        .en      (en1),
        .pos_x   (s_data.pos_x),
        .pos_z   (s_data.pos_z),
        .tgt_x   (cfg.place_target_x),
        .tgt_z   (cfg.place_target_z),
        .sq_x_reg(place_sq_x),
        .sq_z_reg(place_sq_z)
    );

    assign angle[0] = s_data.joint0_angle;
    assign angle[1] = s_data.joint1_angle;
    assign angle[2] = s_data.joint2_angle;
    assign angle[3] = s_data.joint3_angle;
    assign angle[4] = s_data.joint4_angle;

    // Joint lanes: each checks one joint against both arm pose targets.
    for (genvar j = 0; j < NJOINTS; j++) begin : g_joint
        pps_joint_lane #(
            .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
            .JOINT          (j)
        ) u_joint (
            .aclk        (aclk),
            .en          (en1),
            .angle       (angle[j]),
            .joint_tol   (cfg.joint_tol),
            .at_prep_reg (prep_ok[j]),
            .at_grasp_reg(grasp_ok[j])
        );
    end

    pps_merge u_merge (
        .aclk        (aclk),
        .en          (en2),
        .pos_valid   (pos_valid1_reg),
        .pick_sq_x   (pick_sq_x),
        .pick_sq_z   (pick_sq_z),
        .place_sq_x  (place_sq_x),
        .place_sq_z  (place_sq_z),
        .prep_ok     (prep_ok),
        .grasp_ok    (grasp_ok),
        .reach_tol_sq(cfg.reach_tol_sq),
        .flags_reg   (flags)
    );

    // The sequencer only steps when a real word enters the output register.
    pps_seq #(
        .DWELL_WIDTH(DWELL_WIDTH)
    ) u_seq (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load               (en3 && valid2_reg),
        .flags              (flags),
        .grip_dwell_ticks   (cfg.grip_dwell_ticks),
        .release_dwell_ticks(cfg.release_dwell_ticks),
        .result_reg         (m_data)
    );

    // The gripper is closed exactly while the part is held.
    a_grip_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.gripper_open ==
                     !((m_data.phase_out == 4'd3) || (m_data.phase_out == 4'd4) ||
                       (m_data.phase_out == 4'd5) || (m_data.phase_out == 4'd6))))
        else $error("gripper state disagrees with phase");

    // Without an arm command the pose and speed fields stay zero.
    a_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.arm_cmd_valid) |->
            (m_data.arm_pose == POSE_HOME) && (m_data.arm_speed == 5'd0))
        else $error("arm pose or speed set without a command");

    // The wheels only turn while still driving toward a point.
    a_drive_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.drive_enable) |->
            ((m_data.phase_out == 4'd0) || (m_data.phase_out == 4'd5)) &&
            !m_data.arm_cmd_valid)
        else $error("drive enabled outside a drive phase");

    // A result cannot appear without a word having passed the merge stage.
    a_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid3_reg) |-> $past(valid2_reg))
        else $error("result appeared without a merged word");

endmodule
